### hw/rtl/itoa_pkg.sv
// Shared constants, types and helpers for the integer-to-text converter.
`default_nettype none
package itoa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_CHARS_DEF  = 33;
  localparam int RADIX_W        = 6;
  localparam int BUFLEN_W       = 7;
  localparam int CHAR_W         = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int DIV_STEP       = 8;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [RADIX_W-1:0]  RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0]  RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0]  RADIX_RST  = 6'd10;
  localparam logic [RADIX_W-1:0]  DEC_DIGITS = 6'd10;
  localparam logic [BUFLEN_W-1:0] BUFLEN_MIN = 7'd2;
  localparam logic [BUFLEN_W-1:0] BUFLEN_RST = 7'd10;
  localparam logic [CHAR_W-1:0]   MINUS_CODE = 7'h2D;
  localparam logic [CHAR_W-1:0]   ZERO_CODE  = 7'h30;
  localparam logic [CHAR_W-1:0]   ALPHA_CODE = 7'h61;
  localparam logic [CHAR_W-1:0]   NULL_CODE  = 7'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX  = 2'd0,
    CFG_BUFLEN = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [RADIX_W-1:0]  radix;
    logic [BUFLEN_W-1:0] buffer_len;
  } cfg_t;

  typedef struct packed {
    logic bad;
    logic neg;
  } cls_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_CHECK,
    BK_REJ,
    BK_SIGN,
    BK_READ,
    BK_EMIT
  } bk_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    if (d < DEC_DIGITS) begin
      return ZERO_CODE + CHAR_W'(d);
    end else begin
      return ALPHA_CODE + CHAR_W'(d - DEC_DIGITS);
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/itoa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module itoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/itoa_fifo.sv
// Short queue between the front and back parts.
`default_nettype none
module itoa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/itoa_front.sv
// Front part: configuration registers, input acceptance, sign and range checks.
`default_nettype none
module itoa_front #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [itoa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [itoa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [VALUE_BITS-1:0]           value_i,
  output itoa_pkg::cfg_t                       cfg_o,
  output logic                                 push_o,
  output logic      [VALUE_BITS-1:0]           push_mag_o,
  output itoa_pkg::cls_t                       push_cls_o,
  input  wire logic                            full_i
);
  import itoa_pkg::*;

  logic [RADIX_W-1:0]  radix_q;
  logic [BUFLEN_W-1:0] buffer_len_q;
  logic                cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q      <= RADIX_RST;
      buffer_len_q <= BUFLEN_RST;
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_RADIX) begin
        radix_q <= cfg_data_i[RADIX_W-1:0];
      end else if (cfg_index_i == CFG_BUFLEN) begin
        buffer_len_q <= cfg_data_i[BUFLEN_W-1:0];
      end
    end
  end

  assign cfg_o.radix      = radix_q;
  assign cfg_o.buffer_len = buffer_len_q;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  assign push_cls_o.neg = value_i[VALUE_BITS-1];
  assign push_cls_o.bad = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX) ||
                          (buffer_len_q < BUFLEN_MIN);
  // two's complement magnitude; the most negative value maps to 2^(n-1)
  assign push_mag_o = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;

endmodule
`default_nettype wire

### hw/rtl/itoa_back.sv
// Back part: digit extraction by shared serial divider, fit check and character output.
`default_nettype none
module itoa_back #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
  parameter int MAX_CHARS  = itoa_pkg::MAX_CHARS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire itoa_pkg::cfg_t                cfg_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  input  wire logic [VALUE_BITS-1:0]         mag_i,
  input  wire itoa_pkg::cls_t                cls_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [itoa_pkg::CHAR_W-1:0]   char_code_o,
  output logic                               last_o,
  output logic                               rejected_o
);
  import itoa_pkg::*;

  localparam int Chunks = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DivW   = Chunks * DIV_STEP;
  localparam int CkW    = (Chunks > 1) ? $clog2(Chunks) : 1;
  localparam int AW     = $clog2(VALUE_BITS);
  localparam int CntW   = $clog2(VALUE_BITS + 1);
  localparam int CmpW   = CntW + BUFLEN_W + 2;

  bk_state_e            state_q, state_d;
  logic [DivW-1:0]      quo_q, quo_d, quo_sh;
  logic [RADIX_W-1:0]   rem_q, rem_d, rem_w;
  logic [RADIX_W:0]     part;
  logic [DIV_STEP-1:0]  qbits;
  logic [CkW-1:0]       ck_q, ck_d;
  logic [CntW-1:0]      ndig_q, ndig_d;
  logic                 neg_q, neg_d;
  logic [AW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CmpW-1:0]      total;
  logic                 we;
  logic [RADIX_W-1:0]   rdata;
  logic                 slot_free;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    code_q, code_d;
  logic                 last_q, last_d, rej_q, rej_d;

  itoa_ram #(
    .WIDTH(RADIX_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ndig_q[AW-1:0]),
    .wdata_i(rem_w),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  // eight restoring-division steps per cycle on the narrow remainder
  always_comb begin
    rem_w = rem_q;
    part  = '0;
    qbits = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      part = {rem_w, quo_q[DivW-1-i]};
      if (part >= {1'b0, cfg_i.radix}) begin
        part = part - {1'b0, cfg_i.radix};
        qbits[DIV_STEP-1-i] = 1'b1;
      end
      rem_w = part[RADIX_W-1:0];
    end
    quo_sh = (quo_q << DIV_STEP) | DivW'(qbits);
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign total     = CmpW'(ndig_q) + CmpW'(neg_q);

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    ck_d        = ck_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    rd_ptr_d    = rd_ptr_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    code_d      = code_q;
    last_d      = last_q;
    rej_d       = rej_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          quo_d  = DivW'(mag_i);
          rem_d  = '0;
          ck_d   = '0;
          ndig_d = '0;
          neg_d  = cls_i.neg;
          state_d = cls_i.bad ? BK_REJ : BK_DIV;
        end
      end
      BK_DIV: begin
        quo_d = quo_sh;
        rem_d = rem_w;
        ck_d  = ck_q + CkW'(1);
        if (ck_q == CkW'(Chunks - 1)) begin
          we     = 1'b1;
          ndig_d = ndig_q + CntW'(1);
          rem_d  = '0;
          ck_d   = '0;
          if (quo_sh == '0) begin
            state_d = BK_CHECK;
          end
        end
      end
      BK_CHECK: begin
        rd_ptr_d = AW'(ndig_q - CntW'(1));
        if ((total + CmpW'(1) > CmpW'(cfg_i.buffer_len)) || (total > CmpW'(MAX_CHARS))) begin
          state_d = BK_REJ;
        end else if (neg_q) begin
          state_d = BK_SIGN;
        end else begin
          state_d = BK_READ;
        end
      end
      BK_REJ: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          code_d      = NULL_CODE;
          last_d      = 1'b1;
          rej_d       = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          code_d      = MINUS_CODE;
          last_d      = 1'b0;
          rej_d       = 1'b0;
          state_d     = BK_READ;
        end
      end
      BK_READ: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          code_d      = digit_char(rdata);
          last_d      = (rd_ptr_q == '0);
          rej_d       = 1'b0;
          if (rd_ptr_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q - AW'(1);
            state_d  = BK_READ;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      ck_q        <= '0;
      ndig_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ck_q        <= ck_d;
      ndig_q      <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    rd_ptr_q <= rd_ptr_d;
    code_q   <= code_d;
    last_q   <= last_d;
    rej_q    <= rej_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = code_q;
  assign last_o      = last_q;
  assign rejected_o  = rej_q;

endmodule
`default_nettype wire

### hw/rtl/int_to_ascii_radix.sv
// Integer-to-text converter top level, radix 2 to 36.
//
// Input channel (in_valid_i / in_stall_o / value_i): one signed integer per beat.
// Output channel (out_valid_o / out_stall_i): one ASCII character per beat, most
// significant first, optional leading '-', last_o on the final character.
// A failed radix, buffer length or fit check gives one beat with rejected_o set,
// char_code_o zero and last_o set.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 radix, index 1 buffer length;
// ready is always high; the user writes only while the block is idle (unenforced).
// Each digit comes from the serial divider, eight remainder steps per cycle;
// then the fit check, and each emitted digit passes a READ and an EMIT state
// for the digit RAM's registered read.
// A two-entry queue lets further inputs be taken while the back end works.
// Reset sets radix 10 and buffer length 10 and empties queue and output register.
// While the receiver stalls, the output beat holds and the back end waits to emit.
`default_nettype none
module int_to_ascii_radix #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
  parameter int MAX_CHARS  = itoa_pkg::MAX_CHARS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [itoa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [itoa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [VALUE_BITS-1:0]           value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [itoa_pkg::CHAR_W-1:0]     char_code_o,
  output logic                                 last_o,
  output logic                                 rejected_o
);
  import itoa_pkg::*;

  localparam int QW = VALUE_BITS + $bits(cls_t);

  cfg_t                  cfg;
  logic                  push, pop, full, empty;
  logic [VALUE_BITS-1:0] push_mag, pop_mag;
  cls_t                  push_cls, pop_cls;
  logic [QW-1:0]         q_rdata;

  itoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .cfg_o      (cfg),
    .push_o     (push),
    .push_mag_o (push_mag),
    .push_cls_o (push_cls),
    .full_i     (full)
  );

  itoa_fifo #(
    .WIDTH(QW),
    .DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_cls, push_mag}),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(empty)
  );

  assign pop_mag = q_rdata[VALUE_BITS-1:0];
  assign pop_cls = q_rdata[QW-1:VALUE_BITS];

  itoa_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .empty_i    (empty),
    .pop_o      (pop),
    .mag_i      (pop_mag),
    .cls_i      (pop_cls),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_code_o(char_code_o),
    .last_o     (last_o),
    .rejected_o (rejected_o)
  );

endmodule
`default_nettype wire
